/* rtl/kmm_pkg.sv */
// kmm_pkg: shared types and constants for the key matrix monitor/emulator
// no dependencies; used by the top level and the port checker
package kmm_pkg;

   // matrix geometry
   localparam int ROWS = 4;
   localparam int COLS = 3;

   // field widths
   localparam int TIMER_W = 8;
   localparam int ROW_IDX_W = 2;
   localparam int COL_IDX_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // register reset values
   localparam logic [TIMER_W-1:0] PRESS_TICKS_RST = 8'd20;
   localparam logic [TIMER_W-1:0] IDLE_TICKS_RST = 8'd200;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_PRESS_TICKS = 1'b0,
      CSR_IDLE_TICKS  = 1'b1
   } csr_index_type;

   // request opcodes
   typedef enum logic [1:0] {
      OP_SAMPLE   = 2'd0,
      OP_TICK     = 2'd1,
      OP_SIMULATE = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   // result event kinds
   typedef enum logic [2:0] {
      EV_STATUS   = 3'd0,
      EV_PRESS    = 3'd1,
      EV_RELEASE  = 3'd2,
      EV_ACT      = 3'd3,
      EV_DEACT    = 3'd4,
      EV_EMU_STOP = 3'd5
   } event_kind_type;

   // pending result slots, in emission order
   localparam int SLOT_ACT = 0;
   localparam int SLOT_KEY0 = 1;
   localparam int SLOT_ONOFF = SLOT_KEY0 + ROWS * COLS;
   localparam int SLOT_EMU_STOP = SLOT_ONOFF + 1;
   localparam int SLOT_DEACT = SLOT_EMU_STOP + 1;
   localparam int SLOT_STATUS = SLOT_DEACT + 1;
   localparam int SLOTS = SLOT_STATUS + 1;
   localparam int SLOT_W = $clog2(SLOTS);

endpackage

/* rtl/key_matrix_monitor_emulator.sv */
// key_matrix_monitor_emulator: passive key matrix monitor with timed key emulation
// depends on kmm_pkg
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata: opcode[1:0] row_lines[5:2] col_lines[8:6]
//                                      onoff_line[9] sim_row[11:10] sim_col[13:12]
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: event_kind[2:0] key_row[4:3] key_col[6:5]
//                                      is_onoff_key[7] col_drive[10:8] active[11]; rsp_tlast
// csr      in   csr_we                 csr_index, csr_wdata
//
// An item updates the block state in the cycle it is accepted and loads a set of pending results.
// Results leave one per cycle from the pending-result register while rsp is not stalled;
// an item causes 1 to 15 results, and the final status result carries rsp_tlast.
// The next item is accepted in the same cycle its predecessor's status result is taken.
// A stall on rsp holds the current result and blocks req; reset is synchronous, active high.
module key_matrix_monitor_emulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // opcode, row_lines, col_lines, onoff_line, sim_row, sim_col, zero fill
   input  logic [kmm_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // event_kind, key_row, key_col, is_onoff_key, col_drive, active, zero fill
   output logic [kmm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [0:0]                        csr_index,
   input  logic [kmm_pkg::TIMER_W-1:0]       csr_wdata
);

   localparam int ROWS = kmm_pkg::ROWS;
   localparam int COLS = kmm_pkg::COLS;
   localparam int TW = kmm_pkg::TIMER_W;

   // request fields
   logic [1:0]                    req_opcode;
   logic [ROWS-1:0]               req_rows;
   logic [COLS-1:0]               req_cols;
   logic                          req_onoff;
   logic [kmm_pkg::ROW_IDX_W-1:0] req_sim_row;
   logic [kmm_pkg::COL_IDX_W-1:0] req_sim_col;

   assign req_opcode  = req_tdata[1:0];
   assign req_rows    = req_tdata[5:2];
   assign req_cols    = req_tdata[8:6];
   assign req_onoff   = req_tdata[9];
   assign req_sim_row = req_tdata[11:10];
   assign req_sim_col = req_tdata[13:12];

   // configuration and block state
   logic [TW-1:0]                 press_ticks_ff;
   logic [TW-1:0]                 idle_ticks_ff;
   logic [COLS-1:0]               row_col_state_ff [ROWS];
   logic [COLS-1:0]               row_col_state_in [ROWS];
   logic                          onoff_state_ff, onoff_state_in;
   logic [TW-1:0]                 press_timer_ff, press_timer_in;
   logic [TW-1:0]                 activity_timer_ff, activity_timer_in;
   logic [kmm_pkg::ROW_IDX_W-1:0] emu_row_ff, emu_row_in;
   logic [kmm_pkg::COL_IDX_W-1:0] emu_col_ff, emu_col_in;
   logic [COLS-1:0]               drive_mask_ff, drive_mask_in;

   // pending-result register: slot flags plus what the results report
   logic [kmm_pkg::SLOTS-1:0]     pend_ff, pend_in, pend_new;
   logic [COLS-1:0]               b_cols_ff, b_cols_in;
   logic [COLS-1:0]               b_old_drive_ff, b_old_drive_in;
   logic [COLS-1:0]               b_new_drive_ff, b_new_drive_in;
   logic                          b_old_active_ff, b_old_active_in;
   logic                          b_new_active_ff, b_new_active_in;

   logic                          accept;
   logic                          rsp_take;
   logic [kmm_pkg::SLOT_W-1:0]    sel;

   kmm_pkg::event_kind_type       out_kind;
   logic [kmm_pkg::ROW_IDX_W-1:0] out_row;
   logic [kmm_pkg::COL_IDX_W-1:0] out_col;
   logic                          out_onoff;
   logic [COLS-1:0]               out_drive;
   logic                          out_active;

   // handshakes
   assign rsp_tvalid = |pend_ff;
   assign rsp_take   = rsp_tvalid & rsp_tready;
   assign rsp_tlast  = (sel == kmm_pkg::SLOT_W'(kmm_pkg::SLOT_STATUS));
   assign req_tready = ~rsp_tvalid | (rsp_take & rsp_tlast);
   assign accept     = req_tvalid & req_tready;

   // per-item state update and result set
   always_comb begin
      row_col_state_in  = row_col_state_ff;
      onoff_state_in    = onoff_state_ff;
      press_timer_in    = press_timer_ff;
      activity_timer_in = activity_timer_ff;
      emu_row_in        = emu_row_ff;
      emu_col_in        = emu_col_ff;
      drive_mask_in     = drive_mask_ff;
      pend_new          = '0;
      pend_new[kmm_pkg::SLOT_STATUS] = 1'b1;
      if (accept) begin
         case (req_opcode)
            kmm_pkg::OP_SAMPLE: begin
               activity_timer_in = idle_ticks_ff;
               pend_new[kmm_pkg::SLOT_ACT] = (activity_timer_ff == '0);
               if (press_timer_ff != '0) begin
                  // emulation: drive the chosen column while its row is strobed
                  if (!req_rows[emu_row_ff] && (32'(emu_col_ff) < COLS))
                     drive_mask_in = COLS'(1) << emu_col_ff;
                  else
                     drive_mask_in = '0;
               end else begin
                  // scan every strobed row for changed columns
                  for (int r = 0; r < ROWS; r++) begin
                     if (!req_rows[r]) begin
                        for (int c = 0; c < COLS; c++)
                           pend_new[kmm_pkg::SLOT_KEY0 + r * COLS + c] =
                              (req_cols[c] != row_col_state_ff[r][c]);
                        row_col_state_in[r] = req_cols;
                     end
                  end
                  pend_new[kmm_pkg::SLOT_ONOFF] = (req_onoff != onoff_state_ff);
                  onoff_state_in = req_onoff;
               end
            end
            kmm_pkg::OP_TICK: begin
               if (press_timer_ff != '0) begin
                  press_timer_in = press_timer_ff - TW'(1);
                  if (press_timer_ff == TW'(1)) begin
                     drive_mask_in = '0;
                     pend_new[kmm_pkg::SLOT_EMU_STOP] = 1'b1;
                  end
               end
               if (activity_timer_ff != '0) begin
                  activity_timer_in = activity_timer_ff - TW'(1);
                  pend_new[kmm_pkg::SLOT_DEACT] = (activity_timer_ff == TW'(1));
               end
            end
            kmm_pkg::OP_SIMULATE: begin
               drive_mask_in  = '0;
               press_timer_in = press_ticks_ff;
               emu_row_in     = req_sim_row;
               emu_col_in     = req_sim_col;
            end
            default: begin
            end
         endcase
      end
   end

   // next contents of the pending-result register
   always_comb begin
      b_cols_in       = b_cols_ff;
      b_old_drive_in  = b_old_drive_ff;
      b_new_drive_in  = b_new_drive_ff;
      b_old_active_in = b_old_active_ff;
      b_new_active_in = b_new_active_ff;
      pend_in         = pend_ff;
      if (accept) begin
         pend_in         = pend_new;
         b_cols_in       = req_cols;
         b_old_drive_in  = drive_mask_ff;
         b_new_drive_in  = drive_mask_in;
         b_old_active_in = (activity_timer_ff != '0);
         b_new_active_in = (activity_timer_in != '0);
      end else if (rsp_take) begin
         pend_in[sel] = 1'b0;
      end
   end

   // lowest pending slot goes out first
   always_comb begin
      sel = kmm_pkg::SLOT_W'(kmm_pkg::SLOT_STATUS);
      for (int k = kmm_pkg::SLOTS - 1; k >= 0; k--)
         if (pend_ff[k]) sel = kmm_pkg::SLOT_W'(k);
   end

   // fields of the current result
   always_comb begin
      out_kind   = kmm_pkg::EV_STATUS;
      out_row    = '0;
      out_col    = '0;
      out_onoff  = 1'b0;
      out_drive  = b_new_drive_ff;
      out_active = b_new_active_ff;
      if (sel == kmm_pkg::SLOT_W'(kmm_pkg::SLOT_ACT)) begin
         out_kind  = kmm_pkg::EV_ACT;
         out_drive = b_old_drive_ff;
      end
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            if (sel == kmm_pkg::SLOT_W'(kmm_pkg::SLOT_KEY0 + r * COLS + c)) begin
               out_kind = b_cols_ff[c] ? kmm_pkg::EV_RELEASE : kmm_pkg::EV_PRESS;
               out_row  = kmm_pkg::ROW_IDX_W'(r);
               out_col  = kmm_pkg::COL_IDX_W'(c);
            end
         end
      end
      if (sel == kmm_pkg::SLOT_W'(kmm_pkg::SLOT_ONOFF)) begin
         out_kind  = onoff_state_ff ? kmm_pkg::EV_RELEASE : kmm_pkg::EV_PRESS;
         out_onoff = 1'b1;
      end
      if (sel == kmm_pkg::SLOT_W'(kmm_pkg::SLOT_EMU_STOP)) begin
         out_kind   = kmm_pkg::EV_EMU_STOP;
         out_drive  = '0;
         out_active = b_old_active_ff;
      end
      if (sel == kmm_pkg::SLOT_W'(kmm_pkg::SLOT_DEACT)) begin
         out_kind   = kmm_pkg::EV_DEACT;
         out_active = 1'b0;
      end
   end

   assign rsp_tdata = {4'b0000, out_active, out_drive, out_onoff, out_col, out_row, out_kind};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         press_ticks_ff <= kmm_pkg::PRESS_TICKS_RST;
         idle_ticks_ff  <= kmm_pkg::IDLE_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            kmm_pkg::CSR_PRESS_TICKS: press_ticks_ff <= csr_wdata;
            kmm_pkg::CSR_IDLE_TICKS:  idle_ticks_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // block state and pending flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++)
            row_col_state_ff[r] <= '1;
         onoff_state_ff    <= 1'b1;
         press_timer_ff    <= '0;
         activity_timer_ff <= '0;
         drive_mask_ff     <= '0;
         pend_ff           <= '0;
      end else begin
         row_col_state_ff  <= row_col_state_in;
         onoff_state_ff    <= onoff_state_in;
         press_timer_ff    <= press_timer_in;
         activity_timer_ff <= activity_timer_in;
         drive_mask_ff     <= drive_mask_in;
         pend_ff           <= pend_in;
      end
   end

   // emulated key and result payload
   always_ff @(posedge clock) begin
      emu_row_ff      <= emu_row_in;
      emu_col_ff      <= emu_col_in;
      b_cols_ff       <= b_cols_in;
      b_old_drive_ff  <= b_old_drive_in;
      b_new_drive_ff  <= b_new_drive_in;
      b_old_active_ff <= b_old_active_in;
      b_new_active_ff <= b_new_active_in;
   end

endmodule

/* rtl/kmm_port_check.sv */
// kmm_port_check: port-level checks on the key matrix monitor result stream
// depends on kmm_pkg; bound to key_matrix_monitor_emulator below
module kmm_port_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [kmm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   logic [2:0] kind;
   assign kind = rsp_tdata[2:0];

   // tlast marks exactly the status result
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (kind == kmm_pkg::EV_STATUS)))
      else $error("tlast does not match status result");

   // only press and release name a key
   a_key_only_on_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && kind != kmm_pkg::EV_PRESS && kind != kmm_pkg::EV_RELEASE)
         |-> (rsp_tdata[7:3] == '0))
      else $error("key fields set on non-key result");

   // a new item waits until the previous one has finished
   a_no_accept_mid_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !req_tready)
      else $error("item accepted while results still pending");

   // a stalled result holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind key_matrix_monitor_emulator kmm_port_check u_kmm_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
